// File: rtl/core/ugbe_pkg.sv
// ----------------------------------------------------------------------------
// ugbe_pkg - shared definitions for the UTF-8 gap buffer editor
// Capacity, field widths, action and status codes, decoder state and helpers.
// ----------------------------------------------------------------------------
package ugbe_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int PTR_W    = 13;

   typedef enum logic [2:0] {
      ACT_INSERT    = 3'd0,
      ACT_DEL_BACK  = 3'd1,
      ACT_DEL_FWD   = 3'd2,
      ACT_MOVE_BACK = 3'd3,
      ACT_MOVE_FWD  = 3'd4,
      ACT_MOVE_TO   = 3'd5,
      ACT_READ      = 3'd6,
      ACT_NOP       = 3'd7
   } action_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NO_ROOM = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic [1:0]  fault;
      logic [1:0]  pend;
      logic [2:0]  seq_len;
      logic [20:0] partial;
   } dec_state_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      if (b >= 8'hF0) return 3'd4;
      if (b >= 8'hE0) return 3'd3;
      if (b >= 8'hC0) return 3'd2;
      return 3'd1;
   endfunction

endpackage

// File: rtl/core/ugbe_text_ram.sv
// ----------------------------------------------------------------------------
// ugbe_text_ram - text store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ugbe_text_ram
   import ugbe_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/ugbe_utf8_dec.sv
// ----------------------------------------------------------------------------
// ugbe_utf8_dec - streaming UTF-8 check, one byte step
// Lead/continuation checks, overlong and range checks at sequence end.
// ----------------------------------------------------------------------------
module ugbe_utf8_dec
   import ugbe_pkg::*;
(
   input  dec_state_type cur,
   input  logic [7:0]    data_byte,
   output dec_state_type nxt
);

   logic [20:0] cp;
   logic        ok;

   always_comb begin
      nxt = cur;
      cp  = ((cur.partial << 6) | 21'(data_byte & 8'h3F));
      ok  = 1'b1;
      if (cur.fault == ST_INVALID) begin
         nxt = cur;
      end else if (cur.pend == 2'd0) begin
         if (data_byte < 8'h80) begin
            nxt = cur;
         end else if (data_byte < 8'hC0 || data_byte >= 8'hF8) begin
            nxt.fault = ST_INVALID;
         end else begin
            nxt.seq_len = lead_len(data_byte);
            nxt.pend    = 2'(lead_len(data_byte) - 3'd1);
            case (lead_len(data_byte))
               3'd4:    nxt.partial = 21'(data_byte & 8'h07);
               3'd3:    nxt.partial = 21'(data_byte & 8'h0F);
               default: nxt.partial = 21'(data_byte & 8'h1F);
            endcase
         end
      end else if (!is_cont(data_byte)) begin
         nxt.fault = ST_INVALID;
      end else begin
         nxt.partial = cp;
         nxt.pend    = cur.pend - 2'd1;
         if (cur.pend == 2'd1) begin
            case (cur.seq_len)
               3'd2:    ok = cp >= 21'h80 && cp <= 21'h07FF;
               3'd3:    ok = cp >= 21'h0800 && cp <= 21'hFFFF;
               default: ok = cp >= 21'h010000 && cp <= 21'h10FFFF;
            endcase
            if (!ok) begin
               nxt.fault = ST_INVALID;
            end
            nxt.seq_len = 3'd0;
            nxt.partial = 21'd0;
         end
      end
   end

endmodule

// File: rtl/core/utf8_gap_buffer_editor_core.sv
// ----------------------------------------------------------------------------
// utf8_gap_buffer_editor_core - gap buffer text store with UTF-8 insert check
// Sequencer around one text RAM: inserts, code-point walks, gap moves, reads.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser    | tlast
//  req_    | in  | data_byte[7:0] count[20:8] position[32:21] | action   | last
//  rsp_    | out | read_data[7:0] cursor[20:8] used[33:21]    | status   | -
//
// Deletes and moves walk the text: a backward walk reads back byte by byte
// past continuation bytes, a forward walk reads each lead byte and skips
// ahead by its sequence length.
// A gap move then shifts each byte through the RAM, read in S_MRD and
// written in S_MWR.
// Reset empties the text (the gap spans the whole store) and clears the
// decoder state; the RAM needs no clearing.
// A new request is taken as soon as the sequencer is idle, even while the
// previous response still waits on rsp_tready.
// ----------------------------------------------------------------------------
module utf8_gap_buffer_editor_core
   import ugbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], count[20:8], position[32:21]
   input  logic [2:0]  req_tuser,   // action[2:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_data[7:0], cursor[20:8], used[33:21]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_INS   = 13'b0000000000010,
      S_ROLL  = 13'b0000000000100,
      S_DISP  = 13'b0000000001000,
      S_BSTEP = 13'b0000000010000,
      S_BCHK  = 13'b0000000100000,
      S_FSTEP = 13'b0000001000000,
      S_FADD  = 13'b0000010000000,
      S_RDW   = 13'b0000100000000,
      S_MSET  = 13'b0001000000000,
      S_MRD   = 13'b0010000000000,
      S_MWR   = 13'b0100000000000,
      S_DONE  = 13'b1000000000000
   } state_type;

   localparam logic [PTR_W-1:0] CAP = PTR_W'(CAPACITY);

   state_type state_ff, state_in;

   // text geometry and open-string tracking
   logic [PTR_W-1:0] gs_ff, gs_in;        // gap start = cursor
   logic [PTR_W-1:0] gsz_ff, gsz_in;      // gap size
   logic [PTR_W-1:0] origin_ff, origin_in;
   logic             open_ff, open_in;
   dec_state_type    dec_ff, dec_in;

   // latched request
   action_type       act_ff, act_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [PTR_W-1:0] n_ff, n_in;          // code points left
   logic [11:0]      pos_ff, pos_in;

   // walk / move working registers
   logic [PTR_W-1:0] wi_ff, wi_in;
   logic [PTR_W-1:0] target_ff, target_in;
   logic             back_ff, back_in;
   logic [1:0]       status_ff, status_in;
   logic [7:0]       rd_ff, rd_in;

   // response holding register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_rd_ff, rsp_rd_in;
   logic [PTR_W-1:0] rsp_cur_ff, rsp_cur_in;
   logic [PTR_W-1:0] rsp_used_ff, rsp_used_in;

   // RAM port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   dec_state_type dec_base, dec_next;

   ugbe_text_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign dec_base = open_ff ? dec_ff : '0;

   ugbe_utf8_dec u_dec (
      .cur       (dec_base),
      .data_byte (byte_ff),
      .nxt       (dec_next)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_used_ff, rsp_cur_ff, rsp_rd_ff};

   always_comb begin
      logic [PTR_W-1:0] used_w;
      logic [PTR_W-1:0] origin_e;
      logic [PTR_W-1:0] gs_w;
      logic [PTR_W-1:0] gsz_w;
      logic [1:0]       fault_w;
      logic [1:0]       st_w;
      logic [PTR_W-1:0] limit;
      logic [PTR_W-1:0] res;
      logic [PTR_W-1:0] map_a;

      state_in      = state_ff;
      gs_in         = gs_ff;
      gsz_in        = gsz_ff;
      origin_in     = origin_ff;
      open_in       = open_ff;
      dec_in        = dec_ff;
      act_in        = act_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      wi_in         = wi_ff;
      target_in     = target_ff;
      back_in       = back_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_cur_in    = rsp_cur_ff;
      rsp_used_in   = rsp_used_ff;
      ram_we        = 1'b0;
      ram_waddr     = gs_ff[ADDR_W-1:0];
      ram_wdata     = byte_ff;
      ram_re        = 1'b0;
      ram_raddr     = wi_ff[ADDR_W-1:0];

      used_w   = CAP - gsz_ff;
      origin_e = open_ff ? origin_ff : gs_ff;
      gs_w     = gs_ff;
      gsz_w    = gsz_ff;
      fault_w  = dec_next.fault;
      st_w     = ST_OK;
      limit    = (act_ff == ACT_MOVE_TO) ? used_w : CAP;
      res      = (wi_ff > limit) ? limit : wi_ff;
      map_a    = (wi_ff < gs_ff) ? wi_ff : wi_ff + gsz_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = action_type'(req_tuser);
               byte_in  = req_tdata[7:0];
               n_in     = req_tdata[20:8];
               pos_in   = req_tdata[32:21];
               last_in  = req_tlast;
               state_in = (action_type'(req_tuser) == ACT_INSERT) ? S_INS : S_ROLL;
            end
         end
         S_INS: begin
            // byte lands in the gap if there is room; string rolls back on failure
            if (gsz_ff != '0) begin
               ram_we = 1'b1;
               gs_w   = gs_ff + PTR_W'(1);
               gsz_w  = gsz_ff - PTR_W'(1);
            end else if (fault_w == ST_OK) begin
               fault_w = ST_NO_ROOM;
            end
            st_w      = fault_w;
            origin_in = origin_e;
            rd_in     = 8'd0;
            if (last_ff) begin
               if (dec_next.pend != 2'd0) begin
                  st_w = ST_INVALID;
               end
               if (st_w != ST_OK) begin
                  gs_in  = origin_e;
                  gsz_in = gsz_w + (gs_w - origin_e);
               end else begin
                  gs_in  = gs_w;
                  gsz_in = gsz_w;
               end
               dec_in  = '0;
               open_in = 1'b0;
            end else begin
               gs_in        = gs_w;
               gsz_in       = gsz_w;
               dec_in       = dec_next;
               dec_in.fault = fault_w;
               open_in      = 1'b1;
            end
            status_in = st_w;
            state_in  = S_DONE;
         end
         S_ROLL: begin
            // interrupted string is dropped before the action runs
            if (open_ff && gs_ff >= origin_ff) begin
               gs_in  = origin_ff;
               gsz_in = gsz_ff + (gs_ff - origin_ff);
            end
            dec_in    = '0;
            open_in   = 1'b0;
            status_in = ST_OK;
            rd_in     = 8'd0;
            state_in  = S_DISP;
         end
         S_DISP: begin
            case (act_ff) inside
               ACT_DEL_BACK, ACT_MOVE_BACK: begin
                  wi_in    = gs_ff;
                  state_in = S_BSTEP;
               end
               ACT_DEL_FWD, ACT_MOVE_FWD: begin
                  wi_in    = gs_ff + gsz_ff;
                  state_in = S_FSTEP;
               end
               ACT_MOVE_TO: begin
                  wi_in    = '0;
                  state_in = S_FSTEP;
               end
               ACT_READ: begin
                  if (PTR_W'(pos_ff) >= used_w) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = (PTR_W'(pos_ff) < gs_ff) ? pos_ff[ADDR_W-1:0]
                                 : ADDR_W'(PTR_W'(pos_ff) + gsz_ff);
                     state_in  = S_RDW;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_BSTEP: begin
            if (n_ff == '0 || wi_ff == '0) begin
               if (act_ff == ACT_DEL_BACK) begin
                  gsz_in   = gsz_ff + (gs_ff - wi_ff);
                  gs_in    = wi_ff;
                  state_in = S_DONE;
               end else begin
                  target_in = wi_ff;
                  state_in  = S_MSET;
               end
            end else begin
               wi_in     = wi_ff - PTR_W'(1);
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(wi_ff - PTR_W'(1));
               state_in  = S_BCHK;
            end
         end
         S_BCHK: begin
            // keep stepping back over continuation bytes
            if (wi_ff != '0 && is_cont(ram_rdata)) begin
               wi_in     = wi_ff - PTR_W'(1);
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(wi_ff - PTR_W'(1));
            end else begin
               n_in     = n_ff - PTR_W'(1);
               state_in = S_BSTEP;
            end
         end
         S_FSTEP: begin
            if (n_ff == '0 || wi_ff >= limit) begin
               case (act_ff)
                  ACT_DEL_FWD: begin
                     gsz_in   = res - gs_ff;
                     state_in = S_DONE;
                  end
                  ACT_MOVE_FWD: begin
                     target_in = res - gsz_ff;
                     state_in  = S_MSET;
                  end
                  default: begin
                     target_in = res;
                     state_in  = S_MSET;
                  end
               endcase
            end else begin
               ram_re    = 1'b1;
               ram_raddr = (act_ff == ACT_MOVE_TO) ? map_a[ADDR_W-1:0]
                                                   : wi_ff[ADDR_W-1:0];
               state_in  = S_FADD;
            end
         end
         S_FADD: begin
            wi_in    = wi_ff + PTR_W'(lead_len(ram_rdata));
            n_in     = n_ff - PTR_W'(1);
            state_in = S_FSTEP;
         end
         S_RDW: begin
            rd_in    = ram_rdata;
            state_in = S_DONE;
         end
         S_MSET: begin
            wi_in   = gs_ff;
            back_in = target_ff < gs_ff;
            state_in = (target_ff == gs_ff) ? S_DONE : S_MRD;
         end
         S_MRD: begin
            if (wi_ff == target_ff) begin
               gs_in    = target_ff;
               state_in = S_DONE;
            end else begin
               ram_re = 1'b1;
               if (back_ff) begin
                  wi_in     = wi_ff - PTR_W'(1);
                  ram_raddr = ADDR_W'(wi_ff - PTR_W'(1));
               end else begin
                  ram_raddr = ADDR_W'(wi_ff + gsz_ff);
               end
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (back_ff) begin
               ram_waddr = ADDR_W'(wi_ff + gsz_ff);
            end else begin
               ram_waddr = wi_ff[ADDR_W-1:0];
               wi_in     = wi_ff + PTR_W'(1);
            end
            state_in = S_MRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rd_in     = rd_ff;
               rsp_cur_in    = gs_ff;
               rsp_used_in   = used_w;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gs_ff        <= '0;
         gsz_ff       <= CAP;
         origin_ff    <= '0;
         open_ff      <= 1'b0;
         dec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gs_ff        <= gs_in;
         gsz_ff       <= gsz_in;
         origin_ff    <= origin_in;
         open_ff      <= open_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      byte_ff       <= byte_in;
      last_ff       <= last_in;
      n_ff          <= n_in;
      pos_ff        <= pos_in;
      wi_ff         <= wi_in;
      target_ff     <= target_in;
      back_ff       <= back_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // gap start plus gap size never exceeds the store
   a_geometry: assert property (@(posedge clock) disable iff (reset)
      ((PTR_W+1)'(gs_ff) + (PTR_W+1)'(gsz_ff)) <= (PTR_W+1)'(CAPACITY))
      else $error("gap geometry exceeds capacity");

   // no partial sequence survives once a string is closed
   a_dec_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !open_ff) |-> (dec_ff.pend == 2'd0))
      else $error("decoder left pending without open string");

   // insert writes only into a non-empty gap
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS && ram_we) |-> (gsz_ff != '0))
      else $error("insert write with full gap");

   // a finished transaction reaches the response register
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("response not loaded");

endmodule
